@@ hdl/mctu_pkg.sv @@
// ----------------------------------------------------------------------------
// mctu_pkg
// Shared types and constants of the multi-channel timeout unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mctu_pkg;

	// Timeout channels held in the channel memory.
	localparam int NUM_CH = 6;
	localparam int CH_W   = 3;
	localparam int CNT_W  = 16;
	localparam int STAT_W = 8;

	// Channel memory word: {wrap pending, deadline}.
	localparam int ENT_W = CNT_W + 1;

	// Beat widths on the two stream sides.
	localparam int IN_W  = 24;
	localparam int OUT_W = 8;

	localparam logic [CNT_W-1:0] SECOND_RESET = 16'd65500;
	localparam int MS_PER_FAST_TICK_DEF = 4;

	// Channel roles.
	localparam logic [CH_W-1:0] FAST_CH    = 3'd0;
	localparam logic [CH_W-1:0] ELAPSED_CH = 3'd4;

	typedef enum logic [1:0] {
		MODE_SEC   = 2'd0,
		MODE_FAST  = 2'd1,
		MODE_QUERY = 2'd2
	} mode_t;

endpackage

`default_nettype wire

@@ hdl/multi_channel_timeout_unit.sv @@
// ----------------------------------------------------------------------------
// multi_channel_timeout_unit
// Six timeout channels on a slow second tick and a fast tick, one memory
// holding the per-channel deadlines.
// ----------------------------------------------------------------------------
// Input beats on s_* carry a second tick, a fast tick or a channel query.
// Ticks give no output beat; every query gives exactly one status beat on
// m_*. Mode code 3 is dropped silently.
// Throughput is one beat per cycle, ticks and queries freely mixed. An
// accepted beat reads its channel entry from the channel memory into the
// evaluate stage, where it is evaluated and written back, and its status
// is loaded into the output register, so a status reaches m_tdata through
// the evaluate stage and then the output register.
// A query to the channel written just before reads the written word from
// a bypass register.
// When the receiver stalls with a status waiting, the next query is held in
// the evaluate stage and s_tready drops; ticks behind it wait in order.
// After reset the second count is 65500, the fast count is stopped at zero
// and all channels are idle; the channel entries read as idle through
// per-entry valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_timeout_unit #(
	parameter int MS_PER_FAST_TICK = mctu_pkg::MS_PER_FAST_TICK_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	// mode[1:0], channel[4:2], clear[5], duration[21:6], zero fill [23:22]
	input  wire logic [mctu_pkg::IN_W-1:0] s_tdata,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	// status[7:0]
	output logic [mctu_pkg::OUT_W-1:0]     m_tdata
);

	import mctu_pkg::*;

	localparam int MW = $clog2(MS_PER_FAST_TICK + 1);
	localparam int PW = CNT_W + 1 + MW;

	// Scalar state.
	logic [CNT_W-1:0] sec_q, fc_q, sm_q;
	logic             run_q;

	// Channel memory and its entry valid bits.
	logic [ENT_W-1:0] mem_q [NUM_CH];
	logic [NUM_CH-1:0] ent_vld_q;

	// Bypass of the most recent memory write.
	logic             fw_vld_q;
	logic [CH_W-1:0]  fw_addr_q;
	logic [ENT_W-1:0] fw_data_q;

	// Evaluate stage.
	logic             vld_s1;
	mode_t            mode_s1;
	logic [CH_W-1:0]  ch_s1;
	logic             clr_s1;
	logic [CNT_W-1:0] dur_s1;
	logic [ENT_W-1:0] rd_s1;
	logic             rdv_s1;

	// Output register.
	logic              out_vld_q;
	logic [STAT_W-1:0] out_q;

	logic             accept, adv, out_free, is_query;
	logic [CH_W-1:0]  in_ch;
	logic             in_ch_ok;

	logic [CNT_W-1:0] ent_dl;
	logic             ent_wp;

	// Fast channel terms.
	logic             f_arm;
	logic [CNT_W-1:0] f_dl;
	logic [CNT_W:0]   fc_inc;
	logic [PW-1:0]    f_prod;
	logic             f_exp;

	// Second channel terms.
	logic [CNT_W-1:0] room;
	logic             s_arm, s_over;
	logic [CNT_W-1:0] s_dl;
	logic             s_wp_a, s_wp_b, s_exp;
	logic [CNT_W-1:0] s_sm;
	logic [STAT_W-1:0] el_diff;

	// Next state.
	logic [CNT_W-1:0]  sec_d, fc_d, sm_d;
	logic              run_d;
	logic              wr_en;
	logic [ENT_W-1:0]  wr_data;
	logic [STAT_W-1:0] st;

	assign in_ch    = s_tdata[4:2];
	assign in_ch_ok = in_ch < CH_W'(NUM_CH);

	assign is_query = (mode_s1 == MODE_QUERY);
	assign out_free = !out_vld_q || m_tready;
	assign adv      = vld_s1 && (!is_query || out_free);
	assign s_tready = !vld_s1 || adv;
	assign accept   = s_tvalid && s_tready;

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	// Channel memory: one read port at accept, one write port from stage 1.
	always_ff @(posedge clk) begin
		if (accept && in_ch_ok) begin
			rd_s1 <= mem_q[in_ch];
		end
		if (adv && wr_en) begin
			mem_q[ch_s1] <= wr_data;
		end
	end

	// The bypass register always holds the newest word for its address.
	always_comb begin
		if (fw_vld_q && fw_addr_q == ch_s1) begin
			ent_dl = fw_data_q[CNT_W-1:0];
			ent_wp = fw_data_q[CNT_W];
		end else if (rdv_s1) begin
			ent_dl = rd_s1[CNT_W-1:0];
			ent_wp = rd_s1[CNT_W];
		end else begin
			ent_dl = '0;
			ent_wp = 1'b0;
		end
	end

	// Fast channel: fast_count >= deadline / M is the same as
	// (fast_count + 1) * M > deadline.
	assign f_arm  = (ent_dl == '0) && (dur_s1 != '0);
	assign f_dl   = f_arm ? dur_s1 : ent_dl;
	assign fc_inc = {1'b0, fc_q} + (CNT_W+1)'(1);
	assign f_prod = PW'(fc_inc) * PW'(MS_PER_FAST_TICK);
	assign f_exp  = f_prod > PW'(f_dl);

	// Second channels. An arm that passes the wrap leaves the deadline one
	// second past the true wrapped time.
	assign room   = ~sec_q;
	assign s_arm  = (ent_dl == '0) && (dur_s1 != '0);
	assign s_over = dur_s1 > room;
	assign s_dl   = !s_arm ? ent_dl : (s_over ? dur_s1 - room : sec_q + dur_s1);
	assign s_wp_a = (s_arm && s_over) || ent_wp;
	assign s_sm   = (s_arm && ch_s1 == ELAPSED_CH) ? sec_q : sm_q;
	assign s_wp_b = s_wp_a && !(sec_q <= s_dl);
	assign s_exp  = (sec_q >= s_dl) && !s_wp_b;
	assign el_diff = sec_q[STAT_W-1:0] - s_sm[STAT_W-1:0];

	always_comb begin
		sec_d   = sec_q;
		fc_d    = fc_q;
		run_d   = run_q;
		sm_d    = sm_q;
		wr_en   = 1'b0;
		wr_data = {ent_wp, ent_dl};
		st      = '0;
		case (mode_s1)
			MODE_SEC: begin
				sec_d = sec_q + CNT_W'(1);
			end
			MODE_FAST: begin
				if (run_q) begin
					fc_d = fc_q + CNT_W'(1);
				end
			end
			MODE_QUERY: begin
				if (ch_s1 == FAST_CH) begin
					wr_en = 1'b1;
					if (clr_s1 || f_exp) begin
						run_d   = 1'b0;
						fc_d    = '0;
						wr_data = '0;
					end else begin
						run_d   = run_q || f_arm;
						wr_data = {1'b0, f_dl};
						st      = (fc_q == '0) ? STAT_W'(1) : fc_q[STAT_W-1:0];
					end
				end else if (ch_s1 < CH_W'(NUM_CH)) begin
					wr_en = 1'b1;
					if (clr_s1) begin
						wr_data = '0;
					end else begin
						sm_d = s_sm;
						if (s_exp) begin
							wr_data = {s_wp_b, {CNT_W{1'b0}}};
						end else begin
							wr_data = {s_wp_b, s_dl};
							if (ch_s1 == ELAPSED_CH) begin
								// Modulo 256 the late-deadline form is one lower.
								if (s_dl >= s_sm || s_wp_b) begin
									st = el_diff + STAT_W'(1);
								end else begin
									st = el_diff;
								end
							end else begin
								st = STAT_W'(1);
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q     <= SECOND_RESET;
			fc_q      <= '0;
			run_q     <= 1'b0;
			sm_q      <= '0;
			ent_vld_q <= '0;
			fw_vld_q  <= 1'b0;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				sec_q <= sec_d;
				fc_q  <= fc_d;
				run_q <= run_d;
				sm_q  <= sm_d;
			end
			if (adv && wr_en) begin
				ent_vld_q[ch_s1] <= 1'b1;
				fw_vld_q         <= 1'b1;
			end
			if (adv && is_query) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode_t'(s_tdata[1:0]);
			ch_s1   <= in_ch;
			clr_s1  <= s_tdata[5];
			dur_s1  <= s_tdata[21:6];
			rdv_s1  <= in_ch_ok && ent_vld_q[in_ch];
		end
		if (adv && wr_en) begin
			fw_addr_q <= ch_s1;
			fw_data_q <= wr_data;
		end
		if (adv && is_query) begin
			out_q <= st;
		end
	end

`ifndef SYNTH
	// A clear or an expiry on the fast channel leaves the fast count stopped at zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && is_query && ch_s1 == FAST_CH && (clr_s1 || f_exp)
		|=> !run_q && fc_q == '0)
		else $error("fast count not stopped after fast channel clear or expiry");

	// A stored pending wrap always comes with a nonzero deadline.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && wr_en && wr_data[CNT_W] |-> wr_data[CNT_W-1:0] != '0)
		else $error("pending wrap written with an idle deadline");

	// A stopped fast count does not move on a fast tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && mode_s1 == MODE_FAST && !run_q |=> $stable(fc_q))
		else $error("fast count moved while stopped");

	// A query held behind a stalled output keeps the input side closed.
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && is_query && out_vld_q && !m_tready |-> !s_tready)
		else $error("input accepted while a query is held");
`endif

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression of the multi-channel timeout unit.
// ----------------------------------------------------------------------------
// A table of directed beats runs first. It covers unused channels, the ignored
// mode code, zero durations, wrapped arming and the clear flag. Random
// episodes follow. Most arm one channel and then run a burst of ticks and
// queries on it, with some noise beats mixed in; noise episodes send only
// random beats. An in-bench timer model predicts every status beat. Both
// stream sides stall at random, except during one stretch with no stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import mctu_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam int MS_PER_TICK = MS_PER_FAST_TICK_DEF;
	localparam int RANDOM_ITEMS = 1050;
	localparam int IDLE_PCT = 34;
	localparam int STEADY_FROM = 400;
	localparam int STEADY_TO = 600;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [1:0]        mode;
		logic [CH_W-1:0]   chan;
		logic              clr;
		logic [CNT_W-1:0]  dur;
		bit                fixed;
		logic [STAT_W-1:0] want;
	} stim_row_t;

	typedef enum int {EP_SLOW, EP_FAST, EP_NOISE, EP_FAST_LONG} episode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	// Timer model state.
	logic [CNT_W-1:0] sec_now;
	logic [CNT_W-1:0] fast_cnt;
	bit fast_on;
	logic [CNT_W-1:0] due [NUM_CH];
	bit wrap_due [NUM_CH];
	logic [CNT_W-1:0] arm_mark;

	logic [STAT_W-1:0] status_due [$];
	stim_row_t directed [$];

	int errors = 0;
	int work_items = 0;
	int n_ticks = 0;
	int n_queries = 0;
	int n_spare = 0;
	int n_checked = 0;
	int cycle_cnt = 0;
	bit random_phase = 1'b0;
	bit steady = 1'b0;

	multi_channel_timeout_unit #(
		.MS_PER_FAST_TICK(MS_PER_TICK)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("multi_channel_timeout_unit regression: fail");
			$finish;
		end
	end

	function automatic void clear_timers();
		sec_now = SECOND_RESET;
		fast_cnt = '0;
		fast_on = 1'b0;
		arm_mark = '0;
		for (int i = 0; i < NUM_CH; i++) begin
			due[i] = '0;
			wrap_due[i] = 1'b0;
		end
	endfunction

	// Advances the timer model by one beat; returns 1 when a status beat follows.
	function automatic bit next_status(input logic [1:0] mode, input logic [CH_W-1:0] chan,
			input logic clr, input logic [CNT_W-1:0] dur, output logic [STAT_W-1:0] status);
		logic [CNT_W-1:0] now;
		logic [CNT_W-1:0] room;
		logic [CNT_W-1:0] span;
		status = '0;
		now = sec_now;
		if (mode == MODE_SEC) begin
			sec_now = sec_now + 1'b1;
			return 1'b0;
		end
		if (mode == MODE_FAST) begin
			if (fast_on)
				fast_cnt = fast_cnt + 1'b1;
			return 1'b0;
		end
		if (mode != MODE_QUERY)
			return 1'b0;
		if (chan == FAST_CH) begin
			if (clr) begin
				fast_on = 1'b0;
				fast_cnt = '0;
				due[0] = '0;
				return 1'b1;
			end
			if (due[0] == 0 && dur != 0) begin
				due[0] = dur;
				fast_on = 1'b1;
			end
			if (fast_cnt >= due[0] / CNT_W'(MS_PER_TICK)) begin
				fast_on = 1'b0;
				fast_cnt = '0;
				due[0] = '0;
				return 1'b1;
			end
			status = (fast_cnt != 0) ? fast_cnt[STAT_W-1:0] : STAT_W'(1);
			return 1'b1;
		end
		if (chan >= NUM_CH)
			return 1'b1;
		if (clr) begin
			due[chan] = '0;
			wrap_due[chan] = 1'b0;
			return 1'b1;
		end
		if (due[chan] == 0 && dur != 0) begin
			room = CNT_MAX - now;
			// A wrapped deadline lands one second past the true wrap point.
			if (dur > room) begin
				due[chan] = dur - room;
				wrap_due[chan] = 1'b1;
			end else begin
				due[chan] = now + dur;
			end
			if (chan == ELAPSED_CH)
				arm_mark = now;
		end
		if (wrap_due[chan] && now <= due[chan])
			wrap_due[chan] = 1'b0;
		if (now >= due[chan] && !wrap_due[chan]) begin
			due[chan] = '0;
			return 1'b1;
		end
		if (chan == ELAPSED_CH) begin
			if (due[chan] >= arm_mark || wrap_due[chan])
				span = now - arm_mark + 1'b1;
			else
				span = (CNT_MAX - arm_mark) + now + 1'b1;
			status = span[STAT_W-1:0];
			return 1'b1;
		end
		status = STAT_W'(1);
		return 1'b1;
	endfunction

	// Offers one beat after a random idle gap and books its status once accepted.
	task automatic send_item(input logic [1:0] mode, input logic [CH_W-1:0] chan,
			input logic clr, input logic [CNT_W-1:0] dur, input bit fixed,
			input logic [STAT_W-1:0] want);
		logic [STAT_W-1:0] status;
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			s_tdata <= IN_W'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_W - CNT_W - CH_W - 3){1'b0}}, dur, clr, chan, mode};
		do @(posedge clk); while (!s_tready);
		if (next_status(mode, chan, clr, dur, status))
			status_due.push_back(fixed ? want : status);
		if (mode == MODE_SPARE) begin
			n_spare++;
		end else begin
			work_items++;
			if (mode == MODE_QUERY)
				n_queries++;
			else
				n_ticks++;
		end
		steady = random_phase && work_items >= STEADY_FROM && work_items < STEADY_TO;
	endtask

	task automatic random_tick(input logic [1:0] mode);
		send_item(mode, CH_W'($urandom), 1'($urandom), CNT_W'($urandom), 1'b0, '0);
	endtask

	task automatic run_episode(input episode_t kind, input bit first);
		logic [CH_W-1:0] chan;
		logic [CNT_W-1:0] dur;
		int n;
		int r;
		case (kind)
		EP_SLOW: begin
			chan = first ? ELAPSED_CH : CH_W'($urandom_range(1, NUM_CH - 1));
			dur = ($urandom_range(3) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(1, 24));
			send_item(MODE_QUERY, chan, 1'b0, dur, 1'b0, '0);
			n = first ? 40 : $urandom_range(4, 40);
			for (int i = 0; i < n; i++) begin
				r = $urandom_range(19);
				if (r < 12)
					random_tick(MODE_SEC);
				else if (r < 18)
					send_item(MODE_QUERY, chan, 1'b0, CNT_W'($urandom_range(0, 30)), 1'b0, '0);
				else if (r == 18 && !first)
					send_item(MODE_QUERY, chan, 1'b1, CNT_W'($urandom), 1'b0, '0);
				else
					send_item(MODE_QUERY, CH_W'($urandom_range(1, NUM_CH - 1)),
						1'($urandom_range(3) == 0), CNT_W'($urandom_range(0, 30)), 1'b0, '0);
			end
		end
		EP_FAST: begin
			dur = ($urandom_range(3) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(0, 80));
			send_item(MODE_QUERY, FAST_CH, 1'($urandom_range(5) == 0), dur, 1'b0, '0);
			n = $urandom_range(2, 30);
			for (int i = 0; i < n; i++) begin
				r = $urandom_range(19);
				if (r < 14)
					random_tick(MODE_FAST);
				else if (r < 19)
					send_item(MODE_QUERY, FAST_CH, 1'($urandom_range(9) == 0),
						CNT_W'($urandom_range(0, 80)), 1'b0, '0);
				else
					random_tick(MODE_SEC);
			end
		end
		EP_FAST_LONG: begin
			// Runs the fast count past 255 so that a running count reads as zero.
			send_item(MODE_QUERY, FAST_CH, 1'b1, '0, 1'b0, '0);
			send_item(MODE_QUERY, FAST_CH, 1'b0, CNT_MAX, 1'b0, '0);
			for (int i = 1; i <= 260; i++) begin
				random_tick(MODE_FAST);
				if (i % 64 == 0)
					send_item(MODE_QUERY, FAST_CH, 1'b0, CNT_W'($urandom), 1'b0, '0);
			end
		end
		default: begin
			n = $urandom_range(3, 12);
			for (int i = 0; i < n; i++)
				send_item(2'($urandom_range(3)), CH_W'($urandom), 1'($urandom),
					CNT_W'($urandom), 1'b0, '0);
		end
		endcase
	endtask

	// Status sink with random back-pressure.
	initial begin
		logic [STAT_W-1:0] want;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (status_due.size() == 0) begin
					$error("status: expected no beat, got %0d", m_tdata);
					errors++;
				end else begin
					want = status_due.pop_front();
					n_checked++;
					if (m_tdata !== want) begin
						$error("status: expected %0d, got %0d", want, m_tdata);
						errors++;
					end
				end
			end
			m_tready <= arst_n && (steady || $urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		episode_t kind;
		int ep;
		clear_timers();
		directed = '{
			'{MODE_QUERY, 3'd7, 1'b0, 16'hFFFF, 1'b1, 8'd0},
			'{MODE_QUERY, 3'd6, 1'b1, 16'h0000, 1'b1, 8'd0},
			'{MODE_QUERY, 3'd1, 1'b0, 16'h0000, 1'b1, 8'd0},
			'{MODE_QUERY, 3'd0, 1'b0, 16'h0000, 1'b1, 8'd0},
			'{MODE_SPARE, 3'd7, 1'b1, 16'hFFFF, 1'b0, 8'd0},
			'{MODE_FAST,  3'd0, 1'b0, 16'h0000, 1'b0, 8'd0},
			'{MODE_QUERY, 3'd0, 1'b0, 16'h0008, 1'b1, 8'd1},
			'{MODE_FAST,  3'd5, 1'b1, 16'hAAAA, 1'b0, 8'd0},
			'{MODE_FAST,  3'd2, 1'b0, 16'h5555, 1'b0, 8'd0},
			'{MODE_QUERY, 3'd0, 1'b0, 16'h0000, 1'b1, 8'd0},
			'{MODE_QUERY, 3'd4, 1'b0, 16'hFFFF, 1'b0, 8'd0},
			'{MODE_QUERY, 3'd1, 1'b0, 16'h0064, 1'b0, 8'd0},
			'{MODE_QUERY, 3'd4, 1'b0, 16'h000A, 1'b0, 8'd0},
			'{MODE_SEC,   3'd3, 1'b0, 16'h0000, 1'b0, 8'd0},
			'{MODE_SEC,   3'd0, 1'b1, 16'h1234, 1'b0, 8'd0},
			'{MODE_QUERY, 3'd4, 1'b0, 16'h0000, 1'b0, 8'd0},
			'{MODE_QUERY, 3'd2, 1'b1, 16'hFFFF, 1'b1, 8'd0},
			'{MODE_QUERY, 3'd5, 1'b0, 16'h0001, 1'b0, 8'd0},
			'{MODE_SEC,   3'd5, 1'b0, 16'h0000, 1'b0, 8'd0},
			'{MODE_QUERY, 3'd5, 1'b0, 16'h0000, 1'b0, 8'd0},
			'{MODE_QUERY, 3'd0, 1'b0, 16'hFFFF, 1'b0, 8'd0},
			'{MODE_QUERY, 3'd0, 1'b1, 16'h0000, 1'b1, 8'd0},
			'{MODE_QUERY, 3'd3, 1'b0, 16'h8000, 1'b0, 8'd0},
			'{MODE_QUERY, 3'd4, 1'b1, 16'h0000, 1'b1, 8'd0},
			'{MODE_QUERY, 3'd4, 1'b0, 16'h0064, 1'b0, 8'd0}
		};
		wait (arst_n);
		@(posedge clk);
		foreach (directed[i])
			send_item(directed[i].mode, directed[i].chan, directed[i].clr, directed[i].dur,
				directed[i].fixed, directed[i].want);

		// The first two episodes carry the elapsed channel across the second-count wrap
		// and take the fast count past 255; the rest are drawn at random.
		random_phase = 1'b1;
		work_items = 0;
		ep = 0;
		while (work_items < RANDOM_ITEMS) begin
			if (ep == 0)
				kind = EP_SLOW;
			else if (ep == 1)
				kind = EP_FAST_LONG;
			else
				kind = episode_t'($urandom_range(2));
			run_episode(kind, ep == 0);
			ep++;
		end
		s_tvalid <= 1'b0;
		random_phase = 1'b0;
		steady = 1'b0;

		while (status_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d tick beats, %0d queries and %0d ignored beats in %0d episodes.",
			n_ticks, n_queries, n_spare, ep);
		$display("Checked %0d status beats under random stalls on both sides.", n_checked);
		if (errors == 0)
			$display("multi_channel_timeout_unit regression: pass");
		else
			$display("multi_channel_timeout_unit regression: fail");
		$finish;
	end

endmodule
